// ----- rtl/core/baas_pkg.sv -----
package baas_pkg;

    // pixel and colour fields
    localparam int COLOR_W = 8;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [3*COLOR_W-1:0] rgb_t;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_IMAGE_WIDTH  = 3'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT = 3'd1;
    localparam cfg_index_t CFG_BLOCK_WIDTH  = 3'd2;
    localparam cfg_index_t CFG_BLOCK_HEIGHT = 3'd3;
    localparam cfg_index_t CFG_SHADE_MODE   = 3'd4;

    // register widths
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int BLK_BITS   = 7;
    localparam int MODE_BITS  = 2;
    localparam int ROW_W      = 12;

    // register reset values
    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic [BLK_BITS-1:0]   RST_BLOCK_WIDTH  = 7'd8;
    localparam logic [BLK_BITS-1:0]   RST_BLOCK_HEIGHT = 7'd8;

    // shade modes
    localparam logic [MODE_BITS-1:0] SHADE_DIRECT = 2'd0;
    localparam logic [MODE_BITS-1:0] SHADE_INVERT = 2'd1;
    localparam logic [MODE_BITS-1:0] SHADE_NONE   = 2'd2;

    // sizes
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_BLOCK = 64;
    localparam int MAX_HEIGHT    = 4096;
    localparam int SHADE_LEVELS  = 8;
    localparam int LEVEL_W       = 3;
    typedef logic [LEVEL_W-1:0] level_t;

    // luminance weights, 16-bit fraction
    localparam int LUMA_K_W   = 16;
    localparam int LUMA_ACC_W = 24;
    localparam logic [LUMA_K_W-1:0] LUMA_R = 16'd19595;
    localparam logic [LUMA_K_W-1:0] LUMA_G = 16'd38470;
    localparam logic [LUMA_K_W-1:0] LUMA_B = 16'd7471;

    // block sums
    localparam int SUM_W = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

    // divider step counts
    localparam int COL_Q_BITS  = 11;
    localparam int ROW_Q_BITS  = 13;
    localparam int LEVEL_STEPS = 4;
    localparam int AREA_SHIFT  = 8;
    localparam int STEP_W      = 4;

    function automatic color_t shade_lookup(input level_t level);
        color_t code;
        unique case (level)
            3'd0:    code = 8'h40;
            3'd1:    code = 8'h23;
            3'd2:    code = 8'h25;
            3'd3:    code = 8'h2A;
            3'd4:    code = 8'h7C;
            3'd5:    code = 8'h2D;
            3'd6:    code = 8'h2E;
            default: code = 8'hA0;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/baas_pixel_if.sv -----
interface baas_pixel_if;
    import baas_pkg::*;

    logic   valid;
    logic   ready;
    color_t red;
    color_t green;
    color_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ----- rtl/core/baas_shade_if.sv -----
interface baas_shade_if;
    import baas_pkg::*;

    logic   valid;
    logic   ready;
    color_t shade_char;
    logic   char_valid;
    color_t block_red;
    color_t block_green;
    color_t block_blue;
    logic   row_end;
    logic   frame_end;

    modport source (
        output valid, output shade_char, output char_valid, output block_red,
        output block_green, output block_blue, output row_end, output frame_end,
        input ready
    );
    modport sink (
        input valid, input shade_char, input char_valid, input block_red,
        input block_green, input block_blue, input row_end, input frame_end,
        output ready
    );

endinterface

// ----- rtl/core/block_average_ascii_shade.sv -----
// a pixel passes through accept, two multiply-accumulate steps and a store update
// a block's last pixel then takes 4 more restoring steps on the shared subtractor
//   and a finish state to load the output register, which may hold while the sink stalls
// after reset and after every configuration write the block is busy while
//   the shared subtractor works out the complete block columns and rows (11 + 13 steps)
// rst_n is asynchronous; the column stores are not cleared and hold nothing until written
module block_average_ascii_shade #(
    parameter int MAX_WIDTH = baas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = baas_pkg::DEF_MAX_BLOCK
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  baas_pkg::cfg_index_t cfg_index,
    input  baas_pkg::cfg_data_t  cfg_data,
    baas_pixel_if.sink           pixel,
    baas_shade_if.source         shade
);
    import baas_pkg::*;

    // column index and counter widths
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CXW   = ((CW > IMG_W_BITS) ? CW : IMG_W_BITS) + 1;
    localparam int BK    = $clog2(MAX_BLOCK + 1);
    localparam int AW    = 2 * BK;
    localparam int RXW   = IMG_H_BITS + 1;
    // shared subtractor width: covers area << 8, block size << 12 and the block sum
    localparam int DW_A  = AW + AREA_SHIFT;
    localparam int DW_B  = BK + ROW_Q_BITS - 1;
    localparam int DW_AB = (DW_A > DW_B) ? DW_A : DW_B;
    localparam int DW    = (DW_AB > SUM_W) ? DW_AB : SUM_W;
    localparam int QW    = ROW_Q_BITS;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_MUL_G     = 10'b0000000010,
        ST_MUL_B     = 10'b0000000100,
        ST_UPDATE    = 10'b0000001000,
        ST_DIVIDE    = 10'b0000010000,
        ST_FINISH    = 10'b0000100000,
        ST_PREP_LOAD = 10'b0001000000,
        ST_PREP_COLS = 10'b0010000000,
        ST_PREP_ROWS = 10'b0100000000,
        ST_PREP_FIX  = 10'b1000000000
    } state_t;

    // what the current request does to the column stores and the result
    typedef struct packed {
        logic en;
        logic first;
        logic last;
        logic row_end;
        logic frame_end;
    } item_flags_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic [BLK_BITS-1:0]   block_width_reg;
    logic [BLK_BITS-1:0]   block_height_reg;
    logic [MODE_BITS-1:0]  shade_mode_reg;

    // clamped configuration
    logic [IMG_W_BITS-1:0] w_eff;
    logic [IMG_H_BITS-1:0] h_eff;
    logic [BK-1:0]         bw_eff;
    logic [BK-1:0]         bh_eff;

    // derived limits, worked out after each configuration change
    logic [COL_Q_BITS-1:0] full_cols_reg, full_cols_next;
    logic [IMG_H_BITS-1:0] rows_limit_reg, rows_limit_next;
    logic [AW-1:0]         area_reg;

    // raster counters
    logic [CW-1:0]    pixel_column_reg, pixel_column_next;
    logic [ROW_W-1:0] pixel_row_reg, pixel_row_next;
    logic [BK-1:0]    cib_reg, cib_next;
    logic [BK-1:0]    rib_reg, rib_next;
    logic [CW-1:0]    block_column_reg, block_column_next;

    // captured request
    color_t      red_reg, green_reg, blue_reg;
    item_flags_t flags_reg, flags_now;
    logic [CW-1:0] idx_reg;

    // luminance multiply-accumulate
    logic [LUMA_K_W-1:0]   mul_k;
    color_t                mul_x;
    logic [LUMA_ACC_W-1:0] product;
    logic [LUMA_ACC_W-1:0] acc_reg;
    color_t                luma;

    // column stores and their registered read data
    logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
    rgb_t             corner_mem [MAX_WIDTH];
    logic [SUM_W-1:0] sum_rdata_reg;
    rgb_t             corner_rdata_reg;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_new;
    rgb_t             corner_sel;

    // shared subtract and compare unit with its divider registers
    logic [DW-1:0]     unit_a, unit_b;
    logic [DW:0]       unit_diff;
    logic              unit_ge;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dsr_reg, dsr_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]     quo_shift;
    logic [DW-1:0]     rem_step;
    level_t            level;

    // output register
    logic   out_valid_reg, out_valid_next;
    logic   load_out;
    color_t shade_char_reg;
    logic   char_valid_reg;
    color_t block_red_reg, block_green_reg, block_blue_reg;
    logic   row_end_reg, frame_end_reg;

    logic accept;

    // a request is taken only between items and never during a configuration write
    assign pixel.ready = (state_reg == ST_IDLE) && !cfg_write;
    assign accept      = pixel.valid && pixel.ready;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            block_width_reg  <= RST_BLOCK_WIDTH;
            block_height_reg <= RST_BLOCK_HEIGHT;
            shade_mode_reg   <= SHADE_DIRECT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_BITS-1:0];
                CFG_BLOCK_WIDTH:  block_width_reg  <= cfg_data[BLK_BITS-1:0];
                CFG_BLOCK_HEIGHT: block_height_reg <= cfg_data[BLK_BITS-1:0];
                CFG_SHADE_MODE:   shade_mode_reg   <= cfg_data[MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp every size to its legal range
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = IMG_W_BITS'(1);
        else if (int'(image_width_reg) > MAX_WIDTH)
            w_eff = IMG_W_BITS'(MAX_WIDTH);
        else
            w_eff = image_width_reg;

        if (image_height_reg == '0)
            h_eff = IMG_H_BITS'(1);
        else if (int'(image_height_reg) > MAX_HEIGHT)
            h_eff = IMG_H_BITS'(MAX_HEIGHT);
        else
            h_eff = image_height_reg;

        if (block_width_reg == '0)
            bw_eff = BK'(1);
        else if (int'(block_width_reg) > MAX_BLOCK)
            bw_eff = BK'(MAX_BLOCK);
        else
            bw_eff = BK'(block_width_reg);

        if (block_height_reg == '0)
            bh_eff = BK'(1);
        else if (int'(block_height_reg) > MAX_BLOCK)
            bh_eff = BK'(MAX_BLOCK);
        else
            bh_eff = BK'(block_height_reg);
    end

    // ------------------------------------------------------------------
    // request classification from the raster counters before they move
    // ------------------------------------------------------------------
    always_comb
    begin
        logic col_ok;
        logic row_ok;
        logic col_last;
        logic row_last;

        // pixel lies in a complete block column
        col_ok = (CXW'(block_column_reg) < CXW'(full_cols_reg)) && (cib_reg < bw_eff);
        // pixel lies in a block row that fits inside the frame
        row_ok = (rib_reg < bh_eff)
              && (RXW'(pixel_row_reg) >= RXW'(rib_reg))
              && (RXW'(pixel_row_reg) - RXW'(rib_reg) + RXW'(bh_eff) <= RXW'(h_eff));
        col_last = ((BK+1)'(cib_reg) + (BK+1)'(1)) == (BK+1)'(bw_eff);
        row_last = ((BK+1)'(rib_reg) + (BK+1)'(1)) == (BK+1)'(bh_eff);

        flags_now.en      = col_ok && row_ok;
        flags_now.first   = (cib_reg == '0) && (rib_reg == '0);
        flags_now.last    = col_last && row_last;
        flags_now.row_end = (CXW'(block_column_reg) + CXW'(1)) == CXW'(full_cols_reg);
        flags_now.frame_end = flags_now.row_end
            && ((IMG_H_BITS'(pixel_row_reg) + IMG_H_BITS'(1)) == rows_limit_reg);
    end

    // raster counters advance on every request; a counter past a new limit wraps
    always_comb
    begin
        pixel_column_next = pixel_column_reg;
        pixel_row_next    = pixel_row_reg;
        cib_next          = cib_reg;
        rib_next          = rib_reg;
        block_column_next = block_column_reg;

        if (CXW'(pixel_column_reg) + CXW'(1) >= CXW'(w_eff))
        begin
            pixel_column_next = '0;
            cib_next          = '0;
            block_column_next = '0;
            if (IMG_H_BITS'(pixel_row_reg) + IMG_H_BITS'(1) >= h_eff)
            begin
                pixel_row_next = '0;
                rib_next       = '0;
            end
            else
            begin
                pixel_row_next = pixel_row_reg + ROW_W'(1);
                if ((BK+1)'(rib_reg) + (BK+1)'(1) >= (BK+1)'(bh_eff))
                    rib_next = '0;
                else
                    rib_next = rib_reg + BK'(1);
            end
        end
        else
        begin
            pixel_column_next = pixel_column_reg + CW'(1);
            if ((BK+1)'(cib_reg) + (BK+1)'(1) >= (BK+1)'(bw_eff))
            begin
                cib_next          = '0;
                block_column_next = block_column_reg + CW'(1);
            end
            else
            begin
                cib_next = cib_reg + BK'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // luminance: one 16x8 multiplier, red at accept, then green, then blue
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_MUL_G)
        begin
            mul_k = LUMA_G;
            mul_x = green_reg;
        end
        else if (state_reg == ST_MUL_B)
        begin
            mul_k = LUMA_B;
            mul_x = blue_reg;
        end
        else
        begin
            mul_k = LUMA_R;
            mul_x = pixel.red;
        end
    end

    assign product = LUMA_ACC_W'(mul_k) * LUMA_ACC_W'(mul_x);
    // the weights sum to one, so the top byte is the truncated luminance
    assign luma    = acc_reg[LUMA_ACC_W-1 -: COLOR_W];

    // block sum: start fresh on the top-left pixel, otherwise add with saturation
    assign sum_add = (SUM_W+1)'(sum_rdata_reg) + (SUM_W+1)'(luma);
    always_comb
    begin
        if (flags_reg.first)
            sum_new = SUM_W'(luma);
        else if (sum_add[SUM_W])
            sum_new = SUM_MAX;
        else
            sum_new = sum_add[SUM_W-1:0];
    end

    // for a one-pixel block the corner is the pixel itself
    assign corner_sel = flags_reg.first ? {red_reg, green_reg, blue_reg} : corner_rdata_reg;

    // ------------------------------------------------------------------
    // shared subtractor: divider steps, and the final row-limit subtract
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_PREP_FIX)
        begin
            unit_a = DW'(h_eff);
            unit_b = rem_reg;
        end
        else
        begin
            unit_a = rem_reg;
            unit_b = dsr_reg;
        end
    end

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = !unit_diff[DW];
    assign quo_shift = {quo_reg[QW-2:0], unit_ge};
    assign rem_step  = unit_ge ? unit_diff[DW-1:0] : rem_reg;

    // top quotient bit means the average reached 256: cap the level
    assign level = quo_reg[LEVEL_STEPS-1] ? LEVEL_W'(SHADE_LEVELS - 1) : quo_reg[LEVEL_W-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        full_cols_next  = full_cols_reg;
        rows_limit_next = rows_limit_reg;
        load_out        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // a completed block starts the level division: sum / (area << 5), capped
                if (flags_reg.en && flags_reg.last)
                begin
                    rem_next   = DW'(sum_new);
                    dsr_next   = DW'(area_reg) << AREA_SHIFT;
                    quo_next   = '0;
                    cnt_next   = STEP_W'(LEVEL_STEPS - 1);
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next = rem_step;
                dsr_next = dsr_reg >> 1;
                quo_next = quo_shift;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || shade.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PREP_LOAD:
            begin
                // complete block columns: image width / block width
                rem_next   = DW'(w_eff);
                dsr_next   = DW'(bw_eff) << (COL_Q_BITS - 1);
                quo_next   = '0;
                cnt_next   = STEP_W'(COL_Q_BITS - 1);
                state_next = ST_PREP_COLS;
            end
            ST_PREP_COLS:
            begin
                rem_next = rem_step;
                dsr_next = dsr_reg >> 1;
                quo_next = quo_shift;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    full_cols_next = quo_shift[COL_Q_BITS-1:0];
                    // then image height / block height, keeping the remainder
                    rem_next   = DW'(h_eff);
                    dsr_next   = DW'(bh_eff) << (ROW_Q_BITS - 1);
                    quo_next   = '0;
                    cnt_next   = STEP_W'(ROW_Q_BITS - 1);
                    state_next = ST_PREP_ROWS;
                end
            end
            ST_PREP_ROWS:
            begin
                rem_next = rem_step;
                dsr_next = dsr_reg >> 1;
                quo_next = quo_shift;
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_PREP_FIX;
            end
            ST_PREP_FIX:
            begin
                // last pixel row of the last complete block row, plus one
                rows_limit_next = unit_diff[IMG_H_BITS-1:0];
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_PREP_LOAD;
            end
        endcase

        // any configuration write restarts the limit computation
        if (cfg_write)
            state_next = ST_PREP_LOAD;
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (shade.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_PREP_LOAD;
            pixel_column_reg <= '0;
            pixel_row_reg    <= '0;
            cib_reg          <= '0;
            rib_reg          <= '0;
            block_column_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pixel_column_reg <= pixel_column_next;
                pixel_row_reg    <= pixel_row_next;
                cib_reg          <= cib_next;
                rib_reg          <= rib_next;
                block_column_reg <= block_column_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        full_cols_reg  <= full_cols_next;
        rows_limit_reg <= rows_limit_next;

        if (state_reg == ST_PREP_LOAD)
            area_reg <= AW'(bw_eff) * AW'(bh_eff);

        if (accept)
        begin
            red_reg   <= pixel.red;
            green_reg <= pixel.green;
            blue_reg  <= pixel.blue;
            flags_reg <= flags_now;
            idx_reg   <= block_column_reg;
            acc_reg   <= product;
        end
        else if ((state_reg == ST_MUL_G) || (state_reg == ST_MUL_B))
        begin
            acc_reg <= acc_reg + product;
        end

        if (load_out)
        begin
            unique case (shade_mode_reg)
                SHADE_DIRECT:
                begin
                    shade_char_reg <= shade_lookup(level);
                    char_valid_reg <= 1'b1;
                end
                SHADE_INVERT:
                begin
                    shade_char_reg <= shade_lookup(LEVEL_W'(SHADE_LEVELS - 1) - level);
                    char_valid_reg <= 1'b1;
                end
                default:
                begin
                    shade_char_reg <= '0;
                    char_valid_reg <= 1'b0;
                end
            endcase
            block_red_reg   <= corner_sel[3*COLOR_W-1 -: COLOR_W];
            block_green_reg <= corner_sel[2*COLOR_W-1 -: COLOR_W];
            block_blue_reg  <= corner_sel[COLOR_W-1:0];
            row_end_reg     <= flags_reg.row_end;
            frame_end_reg   <= flags_reg.frame_end;
        end
    end

    // column stores: read when a request is taken, written in the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            sum_rdata_reg <= sum_mem[block_column_reg];
        if ((state_reg == ST_UPDATE) && flags_reg.en)
            sum_mem[idx_reg] <= sum_new;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            corner_rdata_reg <= corner_mem[block_column_reg];
        if ((state_reg == ST_UPDATE) && flags_reg.en && flags_reg.first)
            corner_mem[idx_reg] <= {red_reg, green_reg, blue_reg};
    end

    assign shade.valid       = out_valid_reg;
    assign shade.shade_char  = shade_char_reg;
    assign shade.char_valid  = char_valid_reg;
    assign shade.block_red   = block_red_reg;
    assign shade.block_green = block_green_reg;
    assign shade.block_blue  = block_blue_reg;
    assign shade.row_end     = row_end_reg;
    assign shade.frame_end   = frame_end_reg;

endmodule
